// ===== design/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types, constants and lerp helpers of the trilinear grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int ADDR_W      = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int COORD_W     = 8;    // grid index along one axis, up to 255
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int CORNERS     = 8;
    localparam int PROD_W      = 50;   // 32-bit sample times 17-bit weight, signed

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE  = 3'd5;

    // axis 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][DATA_W-1:0] origin;
        logic [2:0][DATA_W-1:0] scale;
    } cfg_t;

    // one classified item travelling from front to back
    typedef struct packed {
        logic [1:0]             mode;
        logic                   outside;
        logic [ADDR_W-1:0]      addr;
        logic [DATA_W-1:0]      value;
        logic [2:0][FRAC_W-1:0] frac;
    } task_t;

    // sample times a 17-bit unsigned weight
    function automatic logic signed [PROD_W-1:0] wmul(input logic signed [DATA_W-1:0] v,
                                                      input logic [FRAC_W:0] w);
        logic signed [FRAC_W+1:0] ws;
        ws = $signed({1'b0, w});
        return PROD_W'(v * ws);
    endfunction

    function automatic logic [FRAC_W:0] weight_lo(input logic [FRAC_W-1:0] f);
        return (17'h1_0000 - {1'b0, f});
    endfunction

    // floor((p + q) / 65536); the result lies between the two samples
    function automatic logic [DATA_W-1:0] lerp_sum(input logic signed [PROD_W-1:0] p,
                                                   input logic signed [PROD_W-1:0] q);
        logic signed [PROD_W:0] s;
        s = {p[PROD_W-1], p} + {q[PROD_W-1], q};
        return s[FRAC_W +: DATA_W];
    endfunction

endpackage

// ===== design/tgi_in_if.sv =====
// ----------------------------------------------------------------------------
// tgi_in_if
// Input item channel: valid/ready handshake with write, read and query payload.
// ----------------------------------------------------------------------------
interface tgi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0]        entry_index;
    logic signed [31:0] entry_value;

    modport source (output valid, mode, pos_x, pos_y, pos_z, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, entry_index, entry_value,
                    output ready);
endinterface

// ===== design/tgi_out_if.sv =====
// ----------------------------------------------------------------------------
// tgi_out_if
// Result item channel: valid/ready handshake with sample value and outside flag.
// ----------------------------------------------------------------------------
interface tgi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic               outside;

    modport source (output valid, sample_value, outside, input ready);
    modport sink   (input valid, sample_value, outside, output ready);
endinterface

// ===== design/tgi_front.sv =====
// ----------------------------------------------------------------------------
// tgi_front
// Accepts items, maps query positions to grid cells and classifies them.
// Four stages: offset, scale multiply, range check, base address.
// ----------------------------------------------------------------------------
module tgi_front #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    tgi_in_if.sink         in_ch,
    input  tgi_pkg::cfg_t  cfg,
    output logic           push,
    output tgi_pkg::task_t push_data,
    input  logic           full
);

    localparam int ADDR_W  = tgi_pkg::ADDR_W;
    localparam int COORD_W = tgi_pkg::COORD_W;
    localparam int DATA_W  = tgi_pkg::DATA_W;
    localparam int FRAC_W  = tgi_pkg::FRAC_W;

    localparam logic [ADDR_W-1:0] X_STRIDE = ADDR_W'((GRID_Y * GRID_Z) % tgi_pkg::STORE_DEPTH);
    localparam logic [ADDR_W-1:0] Y_STRIDE = ADDR_W'(GRID_Z % tgi_pkg::STORE_DEPTH);
    localparam logic [2:0][DATA_W-1:0] LIMIT = {DATA_W'(GRID_Z - 1), DATA_W'(GRID_Y - 1),
                                                DATA_W'(GRID_X - 1)};

    logic en;
    logic [2:0][DATA_W-1:0] pos_in;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]             mode1_reg, mode2_reg, mode3_reg;
    logic [ADDR_W-1:0]      index1_reg, index2_reg, index3_reg;
    logic [DATA_W-1:0]      value1_reg, value2_reg, value3_reg;
    logic [2:0][DATA_W:0]   d1_reg;
    logic [2:0]             nonpos2_reg;
    logic [2:0][63:0]       prod2_reg;
    logic                   inside3_reg;
    logic [2:0]             axis_ok;
    logic [2:0][COORD_W-1:0] ipart3_reg;
    logic [2:0][FRAC_W-1:0]  frac3_reg;
    logic [ADDR_W-1:0]      base;
    tgi_pkg::task_t         task_next;
    tgi_pkg::task_t         task_reg;

    // whole front advances unless the last stage is blocked by a full queue
    assign en          = !v4_reg || !full;
    assign in_ch.ready = en;
    assign push        = v4_reg && !full;
    assign push_data   = task_reg;

    assign pos_in = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};

    // interior test per axis on the truncated Q32.16 coordinate
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            axis_ok[a] = !nonpos2_reg[a] && (prod2_reg[a][63:16] != 48'd0) &&
                         (prod2_reg[a][63:32] < LIMIT[a]);
        end
    end

    // flat base address, wrapped to the store
    assign base = ADDR_W'({{(ADDR_W-COORD_W){1'b0}}, ipart3_reg[0]} * X_STRIDE) +
                  ADDR_W'({{(ADDR_W-COORD_W){1'b0}}, ipart3_reg[1]} * Y_STRIDE) +
                  {{(ADDR_W-COORD_W){1'b0}}, ipart3_reg[2]};

    always_comb
    begin
        task_next.mode  = mode3_reg;
        task_next.value = value3_reg;
        if (mode3_reg == tgi_pkg::MODE_QUERY)
        begin
            task_next.outside = !inside3_reg;
            task_next.addr    = base;
            task_next.frac    = frac3_reg;
        end
        else
        begin
            task_next.outside = 1'b0;
            task_next.addr    = index3_reg;
            task_next.frac    = '0;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid && (in_ch.mode != tgi_pkg::MODE_NONE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg  <= in_ch.mode;
            index1_reg <= in_ch.entry_index;
            value1_reg <= in_ch.entry_value;
            for (int a = 0; a < 3; a++)
            begin
                d1_reg[a] <= {pos_in[a][DATA_W-1], pos_in[a]} -
                             {cfg.origin[a][DATA_W-1], cfg.origin[a]};
            end

            mode2_reg  <= mode1_reg;
            index2_reg <= index1_reg;
            value2_reg <= value1_reg;
            for (int a = 0; a < 3; a++)
            begin
                nonpos2_reg[a] <= d1_reg[a][DATA_W] || (d1_reg[a] == '0);
                prod2_reg[a]   <= 64'(d1_reg[a][DATA_W-1:0]) * 64'(cfg.scale[a]);
            end

            mode3_reg   <= mode2_reg;
            index3_reg  <= index2_reg;
            value3_reg  <= value2_reg;
            inside3_reg <= &axis_ok;
            for (int a = 0; a < 3; a++)
            begin
                ipart3_reg[a] <= prod2_reg[a][32 +: COORD_W];
                frac3_reg[a]  <= prod2_reg[a][31:16];
            end

            task_reg <= task_next;
        end
    end

    // a blocked last stage keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && full) |=> (v4_reg && $stable(task_reg)))
        else $error("front lost an item while the queue was full");
    a_push_gate: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("front pushed into a full queue");
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && full) |-> !in_ch.ready)
        else $error("front ready while blocked");

endmodule

// ===== design/tgi_fifo.sv =====
// ----------------------------------------------------------------------------
// tgi_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tgi_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tgi_pkg::task_t push_data,
    output logic           full,
    input  logic           pop,
    output tgi_pkg::task_t pop_data,
    output logic           empty
);

    localparam int DEPTH = tgi_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    tgi_pkg::task_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/tgi_back.sv =====
// ----------------------------------------------------------------------------
// tgi_back
// Grid store and blend pipeline: corner fetch, then z, y and x lerps.
// Eight copies of the store give the eight corner reads in the same cycle.
// ----------------------------------------------------------------------------
module tgi_back #(
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tgi_pkg::task_t head,
    output logic           pop,
    tgi_out_if.source      out_ch
);

    localparam int ADDR_W  = tgi_pkg::ADDR_W;
    localparam int DATA_W  = tgi_pkg::DATA_W;
    localparam int FRAC_W  = tgi_pkg::FRAC_W;
    localparam int PROD_W  = tgi_pkg::PROD_W;
    localparam int CORNERS = tgi_pkg::CORNERS;

    localparam logic [ADDR_W-1:0] X_STRIDE = ADDR_W'((GRID_Y * GRID_Z) % tgi_pkg::STORE_DEPTH);
    localparam logic [ADDR_W-1:0] Y_STRIDE = ADDR_W'(GRID_Z % tgi_pkg::STORE_DEPTH);

    logic en;
    logic [CORNERS-1:0][ADDR_W-1:0] caddr;

    logic [DATA_W-1:0] store [CORNERS][tgi_pkg::STORE_DEPTH];

    // stage 1: corner reads
    logic                       s1_v_reg, s1_emit_reg, s1_read_reg, s1_out_reg;
    logic [2:0][FRAC_W-1:0]     s1_frac_reg;
    logic [CORNERS-1:0][DATA_W-1:0] s1_rd_reg;
    // stage 2: z products
    logic                       s2_v_reg, s2_emit_reg, s2_out_reg;
    logic [1:0][FRAC_W-1:0]     s2_frac_reg;
    logic signed [PROD_W-1:0]   s2_p_reg [CORNERS];
    // stage 3: z lerps
    logic                       s3_v_reg, s3_emit_reg, s3_out_reg;
    logic [1:0][FRAC_W-1:0]     s3_frac_reg;
    logic [3:0][DATA_W-1:0]     s3_z_reg;
    // stage 4: y products
    logic                       s4_v_reg, s4_emit_reg, s4_out_reg;
    logic [FRAC_W-1:0]          s4_fx_reg;
    logic signed [PROD_W-1:0]   s4_p_reg [4];
    // stage 5: y lerps
    logic                       s5_v_reg, s5_emit_reg, s5_out_reg;
    logic [FRAC_W-1:0]          s5_fx_reg;
    logic [1:0][DATA_W-1:0]     s5_y_reg;
    // stage 6: x products
    logic                       s6_v_reg, s6_emit_reg, s6_out_reg;
    logic signed [PROD_W-1:0]   s6_p_reg [2];
    // output register
    logic                       out_v_reg;
    logic                       out_outside_reg;
    logic [DATA_W-1:0]          out_value_reg;
    logic [CORNERS-1:0][DATA_W-1:0] s1_src;

    // back pipeline moves whenever the output register is free or taken
    assign en  = !out_v_reg || out_ch.ready;
    assign pop = en && !empty;

    assign out_ch.valid        = out_v_reg;
    assign out_ch.sample_value = out_value_reg;
    assign out_ch.outside      = out_outside_reg;

    // corner k: bit 2 steps x, bit 1 steps y, bit 0 steps z
    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            caddr[k] = head.addr + (k[2] ? X_STRIDE : '0) + (k[1] ? Y_STRIDE : '0) +
                       ADDR_W'(k[0]);
        end
    end

    // a read item sees its own entry in every corner
    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
            s1_src[k] = s1_read_reg ? s1_rd_reg[0] : s1_rd_reg[k];
    end

    // grid store copies
    always_ff @(posedge clk)
    begin
        if (pop && (head.mode == tgi_pkg::MODE_WRITE))
        begin
            for (int k = 0; k < CORNERS; k++)
                store[k][head.addr] <= head.value;
        end
        if (en)
        begin
            for (int k = 0; k < CORNERS; k++)
                s1_rd_reg[k] <= store[k][caddr[k]];
        end
    end

    // valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= pop;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            out_v_reg <= s6_v_reg && s6_emit_reg;
        end
    end

    // blend datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg <= (head.mode != tgi_pkg::MODE_WRITE);
            s1_read_reg <= (head.mode == tgi_pkg::MODE_READ);
            s1_out_reg  <= head.outside;
            s1_frac_reg <= head.frac;

            s2_emit_reg <= s1_emit_reg;
            s2_out_reg  <= s1_out_reg;
            s2_frac_reg <= {s1_frac_reg[1], s1_frac_reg[0]};
            for (int m = 0; m < 4; m++)
            begin
                s2_p_reg[2*m]   <= tgi_pkg::wmul(s1_src[2*m],
                                                 tgi_pkg::weight_lo(s1_frac_reg[2]));
                s2_p_reg[2*m+1] <= tgi_pkg::wmul(s1_src[2*m+1], {1'b0, s1_frac_reg[2]});
            end

            s3_emit_reg <= s2_emit_reg;
            s3_out_reg  <= s2_out_reg;
            s3_frac_reg <= s2_frac_reg;
            for (int m = 0; m < 4; m++)
                s3_z_reg[m] <= tgi_pkg::lerp_sum(s2_p_reg[2*m], s2_p_reg[2*m+1]);

            // s3_frac_reg[1] is y, [0] is x
            s4_emit_reg <= s3_emit_reg;
            s4_out_reg  <= s3_out_reg;
            s4_fx_reg   <= s3_frac_reg[0];
            for (int m = 0; m < 2; m++)
            begin
                s4_p_reg[2*m]   <= tgi_pkg::wmul(s3_z_reg[2*m],
                                                 tgi_pkg::weight_lo(s3_frac_reg[1]));
                s4_p_reg[2*m+1] <= tgi_pkg::wmul(s3_z_reg[2*m+1], {1'b0, s3_frac_reg[1]});
            end

            s5_emit_reg <= s4_emit_reg;
            s5_out_reg  <= s4_out_reg;
            s5_fx_reg   <= s4_fx_reg;
            for (int m = 0; m < 2; m++)
                s5_y_reg[m] <= tgi_pkg::lerp_sum(s4_p_reg[2*m], s4_p_reg[2*m+1]);

            s6_emit_reg <= s5_emit_reg;
            s6_out_reg  <= s5_out_reg;
            s6_p_reg[0] <= tgi_pkg::wmul(s5_y_reg[0], tgi_pkg::weight_lo(s5_fx_reg));
            s6_p_reg[1] <= tgi_pkg::wmul(s5_y_reg[1], {1'b0, s5_fx_reg});

            out_outside_reg <= s6_out_reg;
            out_value_reg   <= s6_out_reg ? '0 : tgi_pkg::lerp_sum(s6_p_reg[0], s6_p_reg[1]);
        end
    end

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_outside_reg) |-> (out_value_reg == '0))
        else $error("outside result carries a non-zero value");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |=>
            (out_v_reg && $stable(out_value_reg) && $stable(out_outside_reg)))
        else $error("result changed while the receiver stalled");
    a_pop_gate: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("back popped an empty queue");

endmodule

// ===== design/trilinear_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator
// Grid store with trilinear sampling of Q16.16 positions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries items: mode write stores entry_value at entry_index, mode
//          read returns that entry, mode query samples the grid at pos_x/y/z.
//          Mode 3 is dropped. An item is taken when valid and ready are high.
//   out_ch returns one result per read or query, in item order; writes give
//          none. A query off the grid interior returns 0 with outside set.
//   cfg_we/cfg_index/cfg_data write origin and scale registers while idle.
// Throughput: one item per cycle while the receiver does not stall. The eight
//   corner samples come from eight copies of the store read in the same cycle,
//   and the lerps are pipelined.
// Stages: 4 in the front, then the queue, then 7 in the back.
// Reset: origins clear to 0, scales to 1.0; queue and pipelines empty. The
//   store is not cleared; entries hold nothing useful until written.
// Stall: a stalled receiver freezes the back pipeline; the 4-entry queue then
//   fills and in_ch.ready falls once the front is blocked too.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tgi_in_if.sink                          in_ch,
    tgi_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [tgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgi_pkg::DATA_W-1:0]      cfg_data
);

    tgi_pkg::cfg_t  cfg_reg;
    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    tgi_pkg::task_t push_data;
    tgi_pkg::task_t head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin <= '0;
            cfg_reg.scale  <= {3{32'h0001_0000}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgi_pkg::REG_X_ORIGIN: cfg_reg.origin[0] <= cfg_data;
                tgi_pkg::REG_Y_ORIGIN: cfg_reg.origin[1] <= cfg_data;
                tgi_pkg::REG_Z_ORIGIN: cfg_reg.origin[2] <= cfg_data;
                tgi_pkg::REG_X_SCALE:  cfg_reg.scale[0]  <= cfg_data;
                tgi_pkg::REG_Y_SCALE:  cfg_reg.scale[1]  <= cfg_data;
                tgi_pkg::REG_Z_SCALE:  cfg_reg.scale[2]  <= cfg_data;
                default:               ;
            endcase
        end
    end

    tgi_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    tgi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    tgi_back #(
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
